// File: sv/irg_pkg.sv
// Shared types, constants and helper functions of the ISAAC random generator.
`timescale 1ns / 1ps
`default_nettype none
package irg_pkg;

	typedef logic [31:0] word_t;
	typedef logic [1:0]  op_t;

	localparam op_t OP_SEED_LOAD = 2'd0;
	localparam op_t OP_SCRAMBLE  = 2'd1;
	localparam op_t OP_GENERATE  = 2'd2;

	// stream item layout
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;

	// mixer starting words
	localparam word_t MIX_IV [8] = '{
		32'h1367df5a, 32'h95d90059, 32'hc3163e4b, 32'h0f421ad8,
		32'hd92a4a78, 32'ha51a3c49, 32'hc4efea1b, 32'h30609119
	};

	// accumulator shift amounts of the generator step
	localparam int ACC_SHL_0 = 13;
	localparam int ACC_SHR_1 = 6;
	localparam int ACC_SHL_2 = 2;
	localparam int ACC_SHR_3 = 16;

	// mixer control, one command per cycle
	typedef struct packed {
		logic       init;   // load the starting words
		logic       acc;    // add the read word into lane 0, rotate
		logic       mix;    // one line of the eight-line mix, rotate
		logic       rot;    // plain rotate (store sweep)
		logic [2:0] line;   // mix line number
	} irg_mix_ctl_t;

	// shift of the second lane for each mix line
	function automatic word_t mix_shift(input word_t val, input logic [2:0] line);
		word_t r;
		unique case (line)
			3'd0: r = val << 11;
			3'd1: r = val >> 2;
			3'd2: r = val << 8;
			3'd3: r = val >> 16;
			3'd4: r = val << 10;
			3'd5: r = val >> 4;
			3'd6: r = val << 8;
			3'd7: r = val >> 9;
			default: r = val;
		endcase
		return r;
	endfunction

	// accumulator shift of the generator step, chosen by the low position bits
	function automatic word_t acc_shift(input word_t a, input logic [1:0] sel);
		word_t r;
		unique case (sel)
			2'd0: r = a << ACC_SHL_0;
			2'd1: r = a >> ACC_SHR_1;
			2'd2: r = a << ACC_SHL_2;
			2'd3: r = a >> ACC_SHR_3;
			default: r = a;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/irg_ram.sv
// Generic synchronous RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module irg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: sv/irg_mixer.sv
// Eight-lane seed mixer: lanes rotate by one each command so all work sits on lane 0..3.
`timescale 1ns / 1ps
`default_nettype none
module irg_mixer (
	input  wire logic                  clk,
	input  wire irg_pkg::irg_mix_ctl_t ctl,
	input  wire irg_pkg::word_t        rdata,
	output irg_pkg::word_t             lane0
);
	import irg_pkg::*;

	word_t v_q [8];
	word_t src [8];
	word_t nxt [8];
	word_t w0;

	always_comb begin
		w0 = v_q[0] ^ mix_shift(v_q[1], ctl.line);
		for (int j = 0; j < 8; j++) begin
			src[j] = v_q[j];
		end
		if (ctl.mix) begin
			src[0] = w0;
			src[3] = v_q[3] + w0;
			src[1] = v_q[1] + v_q[2];
		end else if (ctl.acc) begin
			src[0] = v_q[0] + rdata;
		end
		// rotate left by one lane; eight rotations bring lanes home
		for (int j = 0; j < 7; j++) begin
			nxt[j] = src[j+1];
		end
		nxt[7] = src[0];
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			for (int j = 0; j < 8; j++) begin
				v_q[j] <= MIX_IV[j];
			end
		end else if (ctl.mix || ctl.acc || ctl.rot) begin
			for (int j = 0; j < 8; j++) begin
				v_q[j] <= nxt[j];
			end
		end
	end

	assign lane0 = v_q[0];
endmodule
`default_nettype wire

// File: sv/isaac_random_generator_unit.sv
// Top level of the ISAAC random generator: sequencer, generator registers, state RAM.
`timescale 1ns / 1ps
`default_nettype none
// ISAAC generator with 32-bit words over a state RAM of 2**LOG_SIZE words.
// Each input item carries an opcode: seed load (0) writes one state word,
// scramble (1) runs the two-pass seeding over the whole state and clears the
// generator registers, generate (2) returns one random word on the output
// stream; opcode 3 is ignored. Only generate items produce an output item.
// After reset the block first clears the state RAM, one word per cycle, with
// s_axis_tready low. A generate runs four dependent reads and one write that
// share the state RAM's single read and write port; a scramble works through
// each group of eight words with the reads, the eight mix lines and the eight
// writes back, once per pass. The result sits in an output register, so the
// next item is taken while it waits; a generate that finishes while the
// register is still full holds in its last step until the output is taken.
module isaac_random_generator_unit #(
	parameter int LOG_SIZE = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [1:0] opcode, [9:2] seed_index, [41:10] seed_value, rest zero
	input  wire logic [irg_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [31:0] random_word
	output logic      [irg_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
	import irg_pkg::*;

	localparam int SIZE  = 1 << LOG_SIZE;
	localparam int GRP_W = LOG_SIZE - 3;
	localparam logic [8:0] SIZE_W = 9'(SIZE);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE,
		ST_G_A, ST_G_X, ST_G_Y, ST_G_B, ST_G_OUT,
		ST_S_LOAD, ST_S_MIX, ST_S_STORE
	} state_t;

	state_t state_q;

	// input fields
	op_t        in_op;
	logic [7:0] in_idx;
	word_t      in_val;
	assign in_op  = s_axis_tdata[1:0];
	assign in_idx = s_axis_tdata[9:2];
	assign in_val = s_axis_tdata[41:10];

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// generator registers
	word_t               a_q, b_q, c_q, x_q, y_q, out_q;
	logic [LOG_SIZE-1:0] pos_q;
	logic [LOG_SIZE-1:0] clr_q;
	logic                out_valid_q;

	// scramble sequencing
	logic [3:0]       k_q;
	logic [GRP_W-1:0] grp_q;
	logic             pass_q;

	// state RAM port
	logic                we;
	logic [LOG_SIZE-1:0] waddr, raddr;
	word_t               wdata, rdata;

	irg_mix_ctl_t mix_ctl;
	word_t        lane0;

	word_t c_inc, y_sum, b_new;
	logic  out_free;

	assign c_inc    = c_q + 32'd1;
	assign y_sum    = rdata + a_q + b_q;
	assign b_new    = rdata + x_q;
	assign out_free = !out_valid_q || m_axis_tready;

	// RAM port and mixer commands, decided by the sequencer state
	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = y_q;
		// speculative read of the half-way word while idle
		raddr   = {~pos_q[LOG_SIZE-1], pos_q[LOG_SIZE-2:0]};
		mix_ctl = '0;
		mix_ctl.line = k_q[2:0];
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_IDLE: begin
				if (accept && in_op == OP_SEED_LOAD && {1'b0, in_idx} < SIZE_W) begin
					we    = 1'b1;
					waddr = in_idx[LOG_SIZE-1:0];
					wdata = in_val;
				end
				if (accept && in_op == OP_SCRAMBLE) begin
					mix_ctl.init = 1'b1;
				end
			end
			ST_G_A:  raddr = pos_q;
			ST_G_X:  raddr = rdata[2 +: LOG_SIZE];
			ST_G_Y: begin
				// y goes back to the current position
				we    = 1'b1;
				waddr = pos_q;
				wdata = y_sum;
			end
			ST_G_B, ST_G_OUT: raddr = y_q[LOG_SIZE + 2 +: LOG_SIZE];
			ST_S_LOAD: begin
				raddr       = {grp_q, k_q[2:0]};
				mix_ctl.acc = (k_q != 4'd0);
			end
			ST_S_MIX: mix_ctl.mix = 1'b1;
			ST_S_STORE: begin
				we          = 1'b1;
				waddr       = {grp_q, k_q[2:0]};
				wdata       = lane0;
				mix_ctl.rot = 1'b1;
			end
			default: ;
		endcase
	end

	irg_ram #(
		.WIDTH (32),
		.DEPTH (SIZE)
	) u_state_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	irg_mixer u_mixer (
		.clk   (clk),
		.ctl   (mix_ctl),
		.rdata (rdata),
		.lane0 (lane0)
	);

	// sequencer, generator registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			out_q       <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			grp_q       <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a finishing generate refills the output register
			if (state_q == ST_G_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && in_op == OP_GENERATE) begin
						// a new block of outputs bumps the counter into b
						if (pos_q == '0) begin
							c_q <= c_inc;
							b_q <= b_q + c_inc;
						end
						state_q <= ST_G_A;
					end else if (accept && in_op == OP_SCRAMBLE) begin
						k_q     <= '0;
						grp_q   <= '0;
						pass_q  <= 1'b0;
						state_q <= ST_S_LOAD;
					end
				end
				ST_G_A: begin
					a_q     <= (a_q ^ acc_shift(a_q, pos_q[1:0])) + rdata;
					state_q <= ST_G_X;
				end
				ST_G_X: begin
					x_q     <= rdata;
					state_q <= ST_G_Y;
				end
				ST_G_Y: begin
					y_q     <= y_sum;
					state_q <= ST_G_B;
				end
				ST_G_B: state_q <= ST_G_OUT;
				ST_G_OUT: begin
					if (out_free) begin
						b_q     <= b_new;
						out_q   <= b_new;
						pos_q   <= pos_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_S_LOAD: begin
					if (k_q == 4'd8) begin
						k_q     <= '0;
						state_q <= ST_S_MIX;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				ST_S_MIX: begin
					if (k_q == 4'd7) begin
						k_q     <= '0;
						state_q <= ST_S_STORE;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				ST_S_STORE: begin
					if (k_q == 4'd7) begin
						k_q   <= '0;
						grp_q <= grp_q + 1'b1;
						if (&grp_q && pass_q) begin
							// seeding done: restart the generator
							a_q     <= '0;
							b_q     <= '0;
							c_q     <= '0;
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_S_LOAD;
							if (&grp_q) begin
								pass_q <= 1'b1;
							end
						end
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

// File: test/isaac_random_generator_checker.sv
// Stream checker of the ISAAC generator: predicts each random word and compares the outputs.
`timescale 1ns / 1ps
module isaac_random_generator_checker #(
	parameter int LOG_SIZE = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [irg_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic [irg_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output int                                 mismatch_count,
	output int                                 pending_words
);
	import irg_pkg::*;

	localparam int SIZE = 1 << LOG_SIZE;
	localparam int HALF = SIZE >> 1;
	localparam int MASK = SIZE - 1;

	// predicted generator state
	word_t pool [256];
	word_t accum;
	word_t last_word;
	word_t block_count;
	int    step_pos;
	word_t lanes [8];

	word_t expected_words [$];

	initial begin
		mismatch_count = 0;
		pending_words  = 0;
	end

	task automatic flag_mismatch(input string note, input word_t seen, input word_t wanted);
		mismatch_count++;
		$display("%0t ns: %s: got %08h, expected %08h", $time, note, seen, wanted);
	endtask

	// one round of the eight-lane mix
	function automatic void churn_lanes();
		lanes[0] ^= lanes[1] << 11; lanes[3] += lanes[0]; lanes[1] += lanes[2];
		lanes[1] ^= lanes[2] >> 2;  lanes[4] += lanes[1]; lanes[2] += lanes[3];
		lanes[2] ^= lanes[3] << 8;  lanes[5] += lanes[2]; lanes[3] += lanes[4];
		lanes[3] ^= lanes[4] >> 16; lanes[6] += lanes[3]; lanes[4] += lanes[5];
		lanes[4] ^= lanes[5] << 10; lanes[7] += lanes[4]; lanes[5] += lanes[6];
		lanes[5] ^= lanes[6] >> 4;  lanes[0] += lanes[5]; lanes[6] += lanes[7];
		lanes[6] ^= lanes[7] << 8;  lanes[1] += lanes[6]; lanes[7] += lanes[0];
		lanes[7] ^= lanes[0] >> 9;  lanes[2] += lanes[7]; lanes[0] += lanes[1];
	endfunction

	// two passes over the pool, then clear the generator registers
	function automatic void scramble_pool();
		for (int k = 0; k < 8; k++)
			lanes[k] = MIX_IV[k];
		for (int pass = 0; pass < 2; pass++) begin
			for (int base = 0; base < SIZE; base += 8) begin
				for (int k = 0; k < 8; k++)
					lanes[k] += pool[(base + k) & MASK];
				churn_lanes();
				for (int k = 0; k < 8; k++)
					pool[(base + k) & MASK] = lanes[k];
			end
		end
		accum       = '0;
		last_word   = '0;
		block_count = '0;
		step_pos    = 0;
	endfunction

	function automatic word_t next_random_word();
		int    pos;
		word_t a;
		word_t b;
		word_t x;
		word_t y;
		word_t t;
		pos = step_pos & MASK;
		a   = accum;
		b   = last_word;
		if (pos == 0) begin
			block_count += 32'd1;
			b += block_count;
		end
		case (pos & 3)
			0: t = a << 13;
			1: t = a >> 6;
			2: t = a << 2;
			default: t = a >> 16;
		endcase
		a = (a ^ t) + pool[(pos + HALF) & MASK];
		x = pool[pos];
		y = pool[(x >> 2) & MASK] + a + b;
		pool[pos] = y;
		// this read may hit the word just written
		b = pool[(y >> (LOG_SIZE + 2)) & MASK] + x;
		accum     = a;
		last_word = b;
		step_pos  = (pos + 1) & MASK;
		return b;
	endfunction

	always @(posedge clk) begin
		op_t   op;
		int    idx;
		word_t want;
		if (!arst_n) begin
			foreach (pool[i])
				pool[i] = '0;
			accum       = '0;
			last_word   = '0;
			block_count = '0;
			step_pos    = 0;
			expected_words.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0)
					flag_mismatch("random word with none expected", m_axis_tdata[31:0], '0);
				else begin
					want = expected_words.pop_front();
					if (m_axis_tdata[31:0] !== want)
						flag_mismatch("random_word", m_axis_tdata[31:0], want);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				op  = s_axis_tdata[1:0];
				idx = int'(s_axis_tdata[9:2]);
				case (op)
					OP_SEED_LOAD: begin
						if (idx < SIZE)
							pool[idx] = s_axis_tdata[41:10];
					end
					OP_SCRAMBLE: scramble_pool();
					OP_GENERATE: expected_words.push_back(next_random_word());
					default: ;
				endcase
			end
		end
		pending_words = expected_words.size();
	end

endmodule

// File: test/isaac_random_generator_unit_test.sv
// Testbench top of the ISAAC generator: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps
module isaac_random_generator_unit_test;
	import irg_pkg::*;

	localparam int LOG_SIZE    = 8;
	localparam int ITEM_TARGET = 1750;

	// opcode with no function
	localparam op_t OP_UNUSED  = 2'd3;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	logic [M_TDATA_W-1:0]   m_axis_tdata;

	int mismatch_count;
	int pending_words;
	int items_sent = 0;
	bit src_calm   = 1'b0;
	bit sink_calm  = 1'b0;
	int sink_wait  = 0;

	isaac_random_generator_unit #(
		.LOG_SIZE(LOG_SIZE)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	isaac_random_generator_checker #(
		.LOG_SIZE(LOG_SIZE)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatch_count(mismatch_count),
		.pending_words (pending_words)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// output side: after each taken word, maybe hold tready low for a random wait;
	// calm stretches take every word at once
	always @(posedge clk) begin
		int w;
		if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			if (sink_wait == 1)
				m_axis_tready <= 1'b1;
		end else if (m_axis_tvalid && m_axis_tready) begin
			w = sink_calm ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 39) == 0)
				sink_calm <= !sink_calm;
			if (w != 0) begin
				m_axis_tready <= 1'b0;
				sink_wait     <= w;
			end
		end
	end

	// one input item; tvalid stays high into the next item when no gap is drawn
	task automatic send_item(input op_t op, input logic [7:0] idx, input word_t val);
		int gap;
		if (items_sent % 40 == 0 && $urandom_range(0, 3) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, val, idx, op};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n_seed;
		int n_gen;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: cleared state, extremes of the fields, unused opcode,
		// scramble of loaded and of already scrambled state
		send_item(OP_GENERATE, 8'h00, '0);
		send_item(OP_GENERATE, 8'hff, '1);
		send_item(OP_UNUSED, 8'hff, 32'hffffffff);
		send_item(OP_SEED_LOAD, 8'h00, 32'h00000000);
		send_item(OP_SEED_LOAD, 8'hff, 32'hffffffff);
		send_item(OP_SEED_LOAD, 8'h01, 32'h80000000);
		send_item(OP_SEED_LOAD, 8'h80, 32'h00000001);
		send_item(OP_SEED_LOAD, 8'h55, 32'haaaaaaaa);
		send_item(OP_SEED_LOAD, 8'haa, 32'h55555555);
		send_item(OP_SCRAMBLE, 8'h00, '0);
		repeat (6) send_item(OP_GENERATE, 8'h00, '0);
		send_item(OP_SCRAMBLE, 8'hff, '1);
		repeat (3) send_item(OP_GENERATE, 8'h00, '0);

		// random: seed loads, usually a scramble, then a run of generates with
		// some noise; long runs cross the 256-word block boundary
		while (items_sent < ITEM_TARGET) begin
			n_seed = $urandom_range(0, 24);
			repeat (n_seed) begin
				if (items_sent < ITEM_TARGET)
					send_item(OP_SEED_LOAD, 8'($urandom), pick_word());
			end
			if ($urandom_range(0, 3) != 0 && items_sent < ITEM_TARGET)
				send_item(OP_SCRAMBLE, 8'($urandom), $urandom);
			n_gen = $urandom_range(16, 320);
			repeat (n_gen) begin
				if (items_sent < ITEM_TARGET) begin
					case ($urandom_range(0, 31))
						0: send_item(OP_UNUSED, 8'($urandom), $urandom);
						1: send_item(OP_SEED_LOAD, 8'($urandom), pick_word());
						default: send_item(OP_GENERATE, 8'($urandom), $urandom);
					endcase
				end
			end
		end
		send_item(OP_GENERATE, 8'h00, '0);
		s_axis_tvalid <= 1'b0;

		do @(posedge clk); while (pending_words != 0);
		repeat (1700) @(posedge clk);
		if (mismatch_count == 0)
			$display("isaac_random_generator_unit regression: pass");
		else
			$display("isaac_random_generator_unit regression: fail");
		$finish;
	end

	// watchdog, several times the slowest correct run
	initial begin
		#12_000_000;
		$display("isaac_random_generator_unit regression: fail");
		$finish;
	end

endmodule
